// File: hw/rtl/ppwa_pkg.sv
// Shared types and constants for the posed primitive world AABB pipeline.
// Used by every module of the block; depends on nothing else.

package ppwa_pkg;

  // Shape codes of the input item.
  localparam logic [1:0] SHAPE_BOX    = 2'd0;
  localparam logic [1:0] SHAPE_SPHERE = 2'd1;
  localparam logic [1:0] SHAPE_CYL    = 2'd2;
  localparam logic [1:0] SHAPE_OTHER  = 2'd3;

  localparam int QW    = 16;          // quaternion component, Q1.14
  localparam int QFRAC = 14;          // fraction bits of the quaternion and matrix
  localparam int PW    = 2 * QW;      // quaternion product, 28 fraction bits
  localparam int RW    = PW + 3;      // matrix entry before truncation
  localparam int MW    = RW - QFRAC;  // matrix entry after truncation, signed
  localparam int AW    = 20;          // magnitude of a truncated matrix entry
  localparam int HW    = 31;          // half size, unsigned
  localparam int CW    = 32;          // coordinate, signed
  localparam int EW    = AW + HW;     // one |r| * h product
  localparam int SW    = EW + 2;      // sum of three products
  localparam int ACW   = SW + 3;      // corner accumulator, signed
  localparam int BW    = ACW - QFRAC; // bound before saturation

  typedef logic [HW-1:0]        half_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [QW-1:0] quat_t;
  typedef logic [AW-1:0]        rabs_t;
  typedef logic [EW-1:0]        prod_t;
  typedef logic [SW-1:0]        ext_t;

  typedef half_t  [2:0] half3_t;
  typedef coord_t [2:0] coord3_t;
  typedef rabs_t  [8:0] rmat_t;   // row-major: entry (i, j) at 3*i + j
  typedef ext_t   [2:0] ext3_t;

  // Control that travels with each pipeline stage.
  typedef struct packed {
    logic valid;
    logic box_ok;
  } ctl_t;

endpackage

// File: hw/rtl/ppwa_rot.sv
// Rotation stages: quaternion products, then the magnitudes of the nine
// truncated rotation matrix entries. Depends on ppwa_pkg.

module ppwa_rot (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  ppwa_pkg::ctl_t           ctl_i,
  input  ppwa_pkg::quat_t          qw_i,
  input  ppwa_pkg::quat_t          qx_i,
  input  ppwa_pkg::quat_t          qy_i,
  input  ppwa_pkg::quat_t          qz_i,
  input  ppwa_pkg::half3_t         h_i,
  input  ppwa_pkg::coord3_t        pos_i,
  output ppwa_pkg::ctl_t           ctl_o,
  output ppwa_pkg::rmat_t          rabs_o,
  output ppwa_pkg::half3_t         h_o,
  output ppwa_pkg::coord3_t        pos_o
);

  localparam logic signed [ppwa_pkg::RW-1:0] ONE_Q28 =
    ppwa_pkg::RW'(1) << (2 * ppwa_pkg::QFRAC);

  // Stage one: the nine quaternion products.
  ppwa_pkg::ctl_t                   c1_r;
  logic signed [ppwa_pkg::PW-1:0]   xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  ppwa_pkg::half3_t                 h1_r;
  ppwa_pkg::coord3_t                p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= qx_i * qx_i;
      yy_r <= qy_i * qy_i;
      zz_r <= qz_i * qz_i;
      xy_r <= qx_i * qy_i;
      xz_r <= qx_i * qz_i;
      yz_r <= qy_i * qz_i;
      wx_r <= qw_i * qx_i;
      wy_r <= qw_i * qy_i;
      wz_r <= qw_i * qz_i;
      h1_r <= h_i;
      p1_r <= pos_i;
    end
  end

  // Stage two: entries at 28 fraction bits, floored to 14, then magnitude.
  logic signed [ppwa_pkg::RW-1:0] r28   [9];
  logic signed [ppwa_pkg::MW-1:0] rq    [9];
  logic [ppwa_pkg::MW-1:0]        rmag  [9];
  ppwa_pkg::rmat_t                rabs_nxt;

  always_comb begin
    r28[0] = ONE_Q28 - ((ppwa_pkg::RW'(yy_r) + ppwa_pkg::RW'(zz_r)) <<< 1);
    r28[1] = (ppwa_pkg::RW'(xy_r) - ppwa_pkg::RW'(wz_r)) <<< 1;
    r28[2] = (ppwa_pkg::RW'(xz_r) + ppwa_pkg::RW'(wy_r)) <<< 1;
    r28[3] = (ppwa_pkg::RW'(xy_r) + ppwa_pkg::RW'(wz_r)) <<< 1;
    r28[4] = ONE_Q28 - ((ppwa_pkg::RW'(xx_r) + ppwa_pkg::RW'(zz_r)) <<< 1);
    r28[5] = (ppwa_pkg::RW'(yz_r) - ppwa_pkg::RW'(wx_r)) <<< 1;
    r28[6] = (ppwa_pkg::RW'(xz_r) - ppwa_pkg::RW'(wy_r)) <<< 1;
    r28[7] = (ppwa_pkg::RW'(yz_r) + ppwa_pkg::RW'(wx_r)) <<< 1;
    r28[8] = ONE_Q28 - ((ppwa_pkg::RW'(xx_r) + ppwa_pkg::RW'(yy_r)) <<< 1);
    for (int k = 0; k < 9; k++) begin
      // Dropping the low bits of a two's complement value floors it.
      rq[k]       = r28[k][ppwa_pkg::RW-1:ppwa_pkg::QFRAC];
      rmag[k]     = rq[k][ppwa_pkg::MW-1] ? ppwa_pkg::MW'(-rq[k]) : ppwa_pkg::MW'(rq[k]);
      rabs_nxt[k] = rmag[k][ppwa_pkg::AW-1:0];
    end
  end

  ppwa_pkg::ctl_t    c2_r;
  ppwa_pkg::rmat_t   rabs_r;
  ppwa_pkg::half3_t  h2_r;
  ppwa_pkg::coord3_t p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else if (en) begin
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rabs_r <= rabs_nxt;
      h2_r   <= h1_r;
      p2_r   <= p1_r;
    end
  end

  assign ctl_o  = c2_r;
  assign rabs_o = rabs_r;
  assign h_o    = h2_r;
  assign pos_o  = p2_r;

endmodule

// File: hw/rtl/ppwa_ext.sv
// Extent stages: the nine |r| * h products, then the half extent of the
// rotated box along each world axis. Depends on ppwa_pkg.

module ppwa_ext (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ppwa_pkg::ctl_t     ctl_i,
  input  ppwa_pkg::rmat_t    rabs_i,
  input  ppwa_pkg::half3_t   h_i,
  input  ppwa_pkg::coord3_t  pos_i,
  output ppwa_pkg::ctl_t     ctl_o,
  output ppwa_pkg::ext3_t    ext_o,
  output ppwa_pkg::coord3_t  pos_o
);

  ppwa_pkg::ctl_t    c1_r;
  ppwa_pkg::prod_t   m_r [9];
  ppwa_pkg::coord3_t p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        m_r[k] <= ppwa_pkg::EW'(rabs_i[k]) * ppwa_pkg::EW'(h_i[k % 3]);
      end
      p1_r <= pos_i;
    end
  end

  ppwa_pkg::ctl_t    c2_r;
  ppwa_pkg::ext3_t   ext_r;
  ppwa_pkg::coord3_t p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else if (en) begin
      c2_r <= c1_r;
    end
  end

  // The extreme corner along an axis takes every term with the sign of its
  // matrix entry, so the half extent is the row sum of |r| * h.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ext_r[i] <= ppwa_pkg::SW'(m_r[3*i]) + ppwa_pkg::SW'(m_r[3*i+1])
                  + ppwa_pkg::SW'(m_r[3*i+2]);
      end
      p2_r <= p1_r;
    end
  end

  assign ctl_o = c2_r;
  assign ext_o = ext_r;
  assign pos_o = p2_r;

endmodule

// File: hw/rtl/ppwa_bnd.sv
// Bounds stage: position plus and minus the half extent, floored and
// saturated (zero for shapes without a box) and held in the output register. Depends on ppwa_pkg.

module ppwa_bnd (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ppwa_pkg::ctl_t     ctl_i,
  input  ppwa_pkg::ext3_t    ext_i,
  input  ppwa_pkg::coord3_t  pos_i,
  output logic               valid_o,
  output logic               box_valid_o,
  output ppwa_pkg::coord3_t  lo_o,
  output ppwa_pkg::coord3_t  hi_o
);

  localparam logic signed [ppwa_pkg::BW-1:0] MAX_B =
    ppwa_pkg::BW'({1'b0, {(ppwa_pkg::CW-1){1'b1}}});
  localparam logic signed [ppwa_pkg::BW-1:0] MIN_B =
    -MAX_B - ppwa_pkg::BW'(1);

  function automatic ppwa_pkg::coord_t sat_coord(
    input logic signed [ppwa_pkg::BW-1:0] v
  );
    ppwa_pkg::coord_t res;
    if (v > MAX_B) begin
      res = MAX_B[ppwa_pkg::CW-1:0];
    end else if (v < MIN_B) begin
      res = MIN_B[ppwa_pkg::CW-1:0];
    end else begin
      res = v[ppwa_pkg::CW-1:0];
    end
    return res;
  endfunction

  logic signed [ppwa_pkg::ACW-1:0] p_s [3];
  logic signed [ppwa_pkg::ACW-1:0] e_s [3];
  logic signed [ppwa_pkg::ACW-1:0] lo_acc [3];
  logic signed [ppwa_pkg::ACW-1:0] hi_acc [3];
  ppwa_pkg::coord3_t               lo_nxt, hi_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_s[i]    = ppwa_pkg::ACW'(pos_i[i]) <<< ppwa_pkg::QFRAC;
      e_s[i]    = ppwa_pkg::ACW'(ext_i[i]);
      lo_acc[i] = p_s[i] - e_s[i];
      hi_acc[i] = p_s[i] + e_s[i];
      if (ctl_i.box_ok) begin
        lo_nxt[i] = sat_coord(lo_acc[i][ppwa_pkg::ACW-1:ppwa_pkg::QFRAC]);
        hi_nxt[i] = sat_coord(hi_acc[i][ppwa_pkg::ACW-1:ppwa_pkg::QFRAC]);
      end else begin
        lo_nxt[i] = '0;
        hi_nxt[i] = '0;
      end
    end
  end

  logic              valid_r;
  logic              box_valid_r;
  ppwa_pkg::coord3_t lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_valid_r <= ctl_i.box_ok;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
    end
  end

  assign valid_o     = valid_r;
  assign box_valid_o = box_valid_r;
  assign lo_o        = lo_r;
  assign hi_o        = hi_r;

endmodule

// File: hw/rtl/posed_primitive_world_aabb_top.sv
// Top level of the posed primitive world AABB pipeline: input register,
// rotation, extent and bounds stages. Depends on ppwa_pkg, ppwa_rot,
// ppwa_ext and ppwa_bnd.
//
// Each transfer carries one posed box, sphere or cylinder and yields one
// world-space bounding box from the output register; other shapes give
// out_box_valid low and zero bounds. The pipeline takes a new item in every
// cycle unless out_stall holds a result. Its six register stages (input,
// quaternion products, matrix magnitudes, extent products, extent sums,
// output) advance together, so when a finished result is held by out_stall
// the whole pipeline holds and in_stall is raised in the same cycle.
// Rotation is applied from the quaternion as given, without normalisation,
// and bounds saturate at the limits of the 32-bit coordinate format.

module posed_primitive_world_aabb_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_shape,
  input  logic [30:0]        in_size_a,
  input  logic [30:0]        in_size_b,
  input  logic [30:0]        in_size_c,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_box_valid,
  output logic signed [31:0] out_min_x,
  output logic signed [31:0] out_min_y,
  output logic signed [31:0] out_min_z,
  output logic signed [31:0] out_max_x,
  output logic signed [31:0] out_max_y,
  output logic signed [31:0] out_max_z
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Select the half extents for the shape before the first register.
  ppwa_pkg::half3_t h_nxt;
  logic             box_ok_nxt;

  always_comb begin
    h_nxt[0]   = in_size_a;
    h_nxt[1]   = in_size_b;
    h_nxt[2]   = in_size_c;
    box_ok_nxt = 1'b1;
    unique case (in_shape)
      ppwa_pkg::SHAPE_BOX: begin
      end
      ppwa_pkg::SHAPE_SPHERE: begin
        h_nxt[1] = in_size_a;
        h_nxt[2] = in_size_a;
      end
      ppwa_pkg::SHAPE_CYL: begin
        h_nxt[1] = in_size_a;
        h_nxt[2] = in_size_b;
      end
      ppwa_pkg::SHAPE_OTHER: begin
        box_ok_nxt = 1'b0;
      end
      default: begin
        box_ok_nxt = 1'b0;
      end
    endcase
  end

  ppwa_pkg::ctl_t    c0_r;
  ppwa_pkg::half3_t  h0_r;
  ppwa_pkg::coord3_t p0_r;
  ppwa_pkg::quat_t   qw0_r, qx0_r, qy0_r, qz0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (en) begin
      c0_r.valid  <= in_valid;
      c0_r.box_ok <= box_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0_r    <= h_nxt;
      p0_r[0] <= in_pos_x;
      p0_r[1] <= in_pos_y;
      p0_r[2] <= in_pos_z;
      qw0_r   <= in_quat_w;
      qx0_r   <= in_quat_x;
      qy0_r   <= in_quat_y;
      qz0_r   <= in_quat_z;
    end
  end

  ppwa_pkg::ctl_t    rot_ctl, ext_ctl;
  ppwa_pkg::rmat_t   rot_rabs;
  ppwa_pkg::half3_t  rot_h;
  ppwa_pkg::coord3_t rot_pos, ext_pos;
  ppwa_pkg::ext3_t   ext_ext;
  ppwa_pkg::coord3_t bnd_lo, bnd_hi;

  ppwa_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (c0_r),
    .qw_i   (qw0_r),
    .qx_i   (qx0_r),
    .qy_i   (qy0_r),
    .qz_i   (qz0_r),
    .h_i    (h0_r),
    .pos_i  (p0_r),
    .ctl_o  (rot_ctl),
    .rabs_o (rot_rabs),
    .h_o    (rot_h),
    .pos_o  (rot_pos)
  );

  ppwa_ext u_ext (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (rot_ctl),
    .rabs_i (rot_rabs),
    .h_i    (rot_h),
    .pos_i  (rot_pos),
    .ctl_o  (ext_ctl),
    .ext_o  (ext_ext),
    .pos_o  (ext_pos)
  );

  ppwa_bnd u_bnd (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (ext_ctl),
    .ext_i       (ext_ext),
    .pos_i       (ext_pos),
    .valid_o     (out_valid),
    .box_valid_o (out_box_valid),
    .lo_o        (bnd_lo),
    .hi_o        (bnd_hi)
  );

  assign out_min_x = bnd_lo[0];
  assign out_min_y = bnd_lo[1];
  assign out_min_z = bnd_lo[2];
  assign out_max_x = bnd_hi[0];
  assign out_max_y = bnd_hi[1];
  assign out_max_z = bnd_hi[2];

  // A valid box never has its lower corner above its upper corner.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_box_valid |->
      out_min_x <= out_max_x && out_min_y <= out_max_y && out_min_z <= out_max_z)
    else $error("bounding box has min above max");

  // Shapes without a box report zero bounds.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_box_valid |->
      out_min_x == 0 && out_min_y == 0 && out_min_z == 0 &&
      out_max_x == 0 && out_max_y == 0 && out_max_z == 0)
    else $error("invalid shape with non-zero bounds");

  // Nothing leaves the pipeline in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result presented straight after reset");

  // A held result freezes the front of the pipeline too.
  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(c0_r) && $stable(rot_ctl) && $stable(ext_ctl))
    else $error("pipeline moved while the output was held");

endmodule
